// File: rtl/lds_pkg.sv
// shared constants and controller/datapath interface types for the diophantine solver
package lds_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int IN_W           = 32;
    localparam int OUT_W          = 64;
    localparam int CHAIN_DEPTH    = 64;
    localparam int CNT_W          = $clog2(CHAIN_DEPTH) + 1;
    localparam int ADDR_W         = $clog2(CHAIN_DEPTH);

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_gcd;
        logic step;
        logic gcd_init;
        logic rd_issue;
        logic mul_lo;
        logic mul_hi;
        logic upd;
        logic out_load;
        logic out_fail;
    } lds_cmd_t;

    typedef struct packed {
        logic ab_zero;
        logic b_zero;
        logic chain_full;
        logic div_done;
        logic div_exact;
        logic cnt_zero;
    } lds_sts_t;

endpackage

// File: rtl/lds_div.sv
// iterative restoring divider on unsigned magnitudes, one quotient bit per cycle
module lds_div
    import lds_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quot,
    output logic [DATA_WIDTH-1:0] rem
);

    localparam int W   = DATA_WIDTH;
    localparam int CW  = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg[W-1:0];

endmodule

// File: rtl/lds_dpath.sv
// datapath: euclid operands, quotient memory, divider and back-substitution multiply
module lds_dpath
    import lds_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lds_cmd_t                cmd,
    output lds_sts_t                sts,
    input  logic signed [IN_W-1:0]  coef_a,
    input  logic signed [IN_W-1:0]  coef_b,
    input  logic signed [IN_W-1:0]  rhs_c,
    output logic signed [OUT_W-1:0] sol_x,
    output logic signed [OUT_W-1:0] sol_y,
    output logic                    solvable
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = W + 34;

    logic signed [W:0]       a_reg, a_next;
    logic signed [W:0]       b_reg, b_next;
    logic signed [W:0]       c_reg, c_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [OUT_W-1:0]        x_reg, x_next;
    logic [OUT_W-1:0]        y_reg, y_next;
    logic [OUT_W-1:0]        prod_reg, prod_next;
    logic                    negq_reg, negq_next;
    logic                    negr_reg, negr_next;
    logic signed [W:0]       q_rd_reg;
    logic signed [W:0]       quot_mem [CHAIN_DEPTH];
    logic signed [OUT_W-1:0] solx_reg, solx_next;
    logic signed [OUT_W-1:0] soly_reg, soly_next;
    logic                    solv_reg, solv_next;

    logic [W:0]              a_abs, b_abs, c_abs;
    logic [W-1:0]            dvd, dvs;
    logic                    div_done;
    logic [W-1:0]            div_q, div_r;
    logic signed [W:0]       q_s, r_s;
    logic [CNT_W-1:0]        cnt_dec;
    logic signed [PW-1:0]    p_lo, p_hi;

    assign a_abs = a_reg[W] ? -a_reg : a_reg;
    assign b_abs = b_reg[W] ? -b_reg : b_reg;
    assign c_abs = c_reg[W] ? -c_reg : c_reg;
    assign dvd   = cmd.div_gcd ? c_abs[W-1:0] : a_abs[W-1:0];
    assign dvs   = cmd.div_gcd ? a_abs[W-1:0] : b_abs[W-1:0];

    lds_div #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign q_s     = negq_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign r_s     = negr_reg ? -$signed({1'b0, div_r}) : $signed({1'b0, div_r});
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign p_lo    = q_rd_reg * $signed({1'b0, y_reg[31:0]});
    assign p_hi    = q_rd_reg * $signed({1'b0, y_reg[63:32]});

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        prod_next = prod_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        solx_next = solx_reg;
        soly_next = soly_reg;
        solv_next = solv_reg;
        if (cmd.load)
        begin
            a_next   = {coef_a[W-1], coef_a[W-1:0]};
            b_next   = {coef_b[W-1], coef_b[W-1:0]};
            c_next   = {rhs_c[W-1], rhs_c[W-1:0]};
            cnt_next = '0;
        end
        if (cmd.div_start)
        begin
            if (cmd.div_gcd)
            begin
                negq_next = c_reg[W] ^ a_reg[W];
                negr_next = c_reg[W];
            end
            else
            begin
                negq_next = a_reg[W] ^ b_reg[W];
                negr_next = a_reg[W];
            end
        end
        if (cmd.step)
        begin
            a_next   = b_reg;
            b_next   = r_s;
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.gcd_init)
        begin
            x_next = OUT_W'(q_s);
            y_next = '0;
        end
        if (cmd.rd_issue)
            cnt_next = cnt_dec;
        if (cmd.mul_lo)
            prod_next = OUT_W'(p_lo);
        if (cmd.mul_hi)
            prod_next = prod_reg + {p_hi[31:0], 32'd0};
        if (cmd.upd)
        begin
            x_next = y_reg;
            y_next = x_reg - prod_reg;
        end
        if (cmd.out_load)
        begin
            solx_next = cmd.out_fail ? '0 : $signed(x_reg);
            soly_next = cmd.out_fail ? '0 : $signed(y_reg);
            solv_next = !cmd.out_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        solx_reg <= solx_next;
        soly_reg <= soly_next;
        solv_reg <= solv_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
            quot_mem[cnt_reg[ADDR_W-1:0]] <= q_s;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
            q_rd_reg <= quot_mem[cnt_dec[ADDR_W-1:0]];
    end

    assign sts.ab_zero    = (a_reg == '0) && (b_reg == '0);
    assign sts.b_zero     = (b_reg == '0);
    assign sts.chain_full = (cnt_reg == CNT_W'(CHAIN_DEPTH));
    assign sts.div_done   = div_done;
    assign sts.div_exact  = (div_r == '0);
    assign sts.cnt_zero   = (cnt_reg == '0);

    assign sol_x    = solx_reg;
    assign sol_y    = soly_reg;
    assign solvable = solv_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CHAIN_DEPTH))
        else $error("quotient count beyond chain depth");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.out_fail |=> sol_x == '0 && sol_y == '0 && !solvable)
        else $error("unsolvable result not cleared");
`endif

endmodule

// File: rtl/lds_ctrl.sv
// controller: sequences forward euclid chain, gcd check, back-substitution and output
module lds_ctrl
    import lds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  lds_sts_t sts,
    output lds_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ZCHK  = 4'd1;
    localparam logic [3:0] S_LOOP  = 4'd2;
    localparam logic [3:0] S_DGO   = 4'd3;
    localparam logic [3:0] S_DWAIT = 4'd4;
    localparam logic [3:0] S_GGO   = 4'd5;
    localparam logic [3:0] S_GWAIT = 4'd6;
    localparam logic [3:0] S_BCHK  = 4'd7;
    localparam logic [3:0] S_BM1   = 4'd8;
    localparam logic [3:0] S_BM2   = 4'd9;
    localparam logic [3:0] S_BUPD  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       fail_reg, fail_next;
    logic       ov_reg, ov_next;
    logic       slot_free;

    assign slot_free = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        fail_next  = fail_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    fail_next  = 1'b0;
                    state_next = S_ZCHK;
                end
            end
            S_ZCHK:
            begin
                if (sts.ab_zero)
                begin
                    fail_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                    state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (sts.b_zero || sts.chain_full)
                    state_next = S_GGO;
                else
                    state_next = S_DGO;
            end
            S_DGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_GGO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_gcd   = 1'b1;
                state_next    = S_GWAIT;
            end
            S_GWAIT:
            begin
                if (sts.div_done)
                begin
                    if (sts.div_exact)
                    begin
                        cmd.gcd_init = 1'b1;
                        state_next   = S_BCHK;
                    end
                    else
                    begin
                        fail_next  = 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_BCHK:
            begin
                if (sts.cnt_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_BM1;
                end
            end
            S_BM1:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_BM2;
            end
            S_BM2:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_BUPD;
            end
            S_BUPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_BCHK;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_fail = fail_reg;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fail_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fail_reg  <= fail_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_ZCHK)
        else $error("accepted transaction did not start the solver");
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside finish");
`endif

endmodule

// File: rtl/linear_diophantine_solver.sv
// top level of the linear diophantine solver
//
//  channel  signals                               direction  role
//  input    in_valid, in_stall, coef_a/b, rhs_c   in         one equation per transaction
//  output   out_valid, out_stall, sol_x/y, solv.  out        one result per transaction
//
// a transaction runs n euclid steps (up to about 46 at 32 bits); its length is set by
// the bit-serial divider and the back step: read, low multiply, high multiply, update
// one equation in work at a time; a finished result waits in the output register
// reset is asynchronous, active low, and clears only control state
// a stalled output holds the next result in the finish state until the register frees
module linear_diophantine_solver
    import lds_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  coef_a,
    input  logic signed [IN_W-1:0]  coef_b,
    input  logic signed [IN_W-1:0]  rhs_c,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] sol_x,
    output logic signed [OUT_W-1:0] sol_y,
    output logic                    solvable
);

    lds_cmd_t cmd;
    lds_sts_t sts;

    lds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lds_dpath #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .rhs_c    (rhs_c),
        .sol_x    (sol_x),
        .sol_y    (sol_y),
        .solvable (solvable)
    );

endmodule

// File: tb/tb_linear_diophantine_solver.sv
// self-checking testbench for the linear diophantine solver
module tb_linear_diophantine_solver;
    import lds_pkg::*;

    typedef struct {
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] c;
    } equation_t;

    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             ok;
    } solution_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [IN_W-1:0]  coef_a = '0;
    logic signed [IN_W-1:0]  coef_b = '0;
    logic signed [IN_W-1:0]  rhs_c = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] sol_x;
    logic signed [OUT_W-1:0] sol_y;
    logic                    solvable;

    equation_t pending_eqs[$];
    solution_t expected_sols[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_req = 1'b0;
    logic      hold_on = 1'b0;
    int        errors = 0;

    linear_diophantine_solver dut (.*);

    always #6 clk = ~clk;

    function automatic solution_t solve_eq(equation_t e);
        solution_t       s;
        longint          a, b, c, r, g;
        longint          q[64];
        int              n;
        logic [63:0]     x, y, nx;
        a = longint'(signed'(e.a));
        b = longint'(signed'(e.b));
        c = longint'(signed'(e.c));
        s.x = '0;
        s.y = '0;
        s.ok = 1'b0;
        n = 0;
        if (a == 0 && b == 0)
            return s;
        while (b != 0 && n < 64)
        begin
            r = a % b;
            q[n] = a / b;
            n++;
            a = b;
            b = r;
        end
        g = a;
        if (g == 0 || c % g != 0)
            return s;
        x = c / g;
        y = '0;
        while (n > 0)
        begin
            n--;
            nx = y;
            y = x - q[n] * y;
            x = nx;
        end
        s.x = x;
        s.y = y;
        s.ok = 1'b1;
        return s;
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_eq(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        equation_t e;
        e.a = a;
        e.b = b;
        e.c = c;
        pending_eqs.push_back(e);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
                expected_sols.push_back(solve_eq('{coef_a, coef_b, rhs_c}));
            if (pending_eqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                equation_t e;
                e = pending_eqs.pop_front();
                coef_a <= e.a;
                coef_b <= e.b;
                rhs_c <= e.c;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold
    always
    begin
        @(posedge hold_req);
        hold_on <= 1'b1;
        repeat (6000) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                solution_t s;
                if (expected_sols.size() == 0)
                begin
                    $error("result with no equation pending");
                    errors++;
                end
                else
                begin
                    s = expected_sols.pop_front();
                    if (sol_x !== s.x)
                    begin
                        $error("sol_x expected %0d actual %0d", $signed(s.x), sol_x);
                        errors++;
                    end
                    if (sol_y !== s.y)
                    begin
                        $error("sol_y expected %0d actual %0d", $signed(s.y), sol_y);
                        errors++;
                    end
                    if (solvable !== s.ok)
                    begin
                        $error("solvable expected %0d actual %0d", s.ok, solvable);
                        errors++;
                    end
                end
            end
            if (hold_on)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic drain();
        while (pending_eqs.size() > 0 || in_valid || expected_sols.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int k;
        push_eq(0, 0, 0);
        push_eq(0, 0, 5);
        push_eq(0, 7, 21);
        push_eq(0, 7, 22);
        push_eq(9, 0, 27);
        push_eq(9, 0, 28);
        push_eq(32'h8000_0000, 32'hffff_ffff, 32'h8000_0000);
        push_eq(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_eq(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_eq(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        push_eq(6, 4, 7);
        push_eq(6, 4, 8);
        push_eq(-6, 4, -8);
        push_eq(1836311903, 1134903170, 1);
        push_eq(-1836311903, 1134903170, 32'h8000_0001);
        push_eq(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_eq(1, 1, 0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        drain();
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4)
                hold_req = 1'b1;
            for (k = 0; k < 70; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_eq(pick_val(), pick_val(), pick_val());
                else if ($urandom_range(0, 3) == 0)
                    push_eq(pick_val(), pick_val(),
                            32'($signed($urandom_range(0, 30)) - 15));
                else
                    push_eq(pick_val(), pick_val(), $urandom);
            end
            drain();
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(12 * 4000000);
        $display("simulation failed");
        $finish;
    end

endmodule
